// ===== hw/rtl/bdes_pkg.sv =====
// Shared types, sizes and codes for the bounded double-ended stack.
// Has no dependencies. Every other file in hw/rtl imports it.
package bdes_pkg;

   localparam int DEPTH  = 128;
   localparam int WORD_W = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // The bottom word is gathered by a three-level OR tree of sixteen-way groups.
   localparam int GRP    = 16;
   localparam int LVL1_N = (DEPTH + GRP - 1) / GRP;
   localparam int LVL2_N = (LVL1_N + GRP - 1) / GRP;

   localparam logic [1:0] ACT_PUSH_TOP    = 2'd0;
   localparam logic [1:0] ACT_POP_TOP     = 2'd1;
   localparam logic [1:0] ACT_PUSH_BOTTOM = 2'd2;
   localparam logic [1:0] ACT_POP_BOTTOM  = 2'd3;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [IDX_W-1:0]         idx_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic    push_top;
      logic    pop_top;
      logic    push_bot;
      cnt_type cnt;
      cnt_type cnt_next;
   } ctrl_type;

endpackage

// ===== hw/rtl/bdes_cell.sv =====
// One storage cell of the word chain; cell 0 holds the top word.
// Depends on bdes_pkg.
module bdes_cell (
   input  logic              clock,
   input  bdes_pkg::idx_type  cell_index,
   input  bdes_pkg::ctrl_type ctrl,
   input  bdes_pkg::word_type value,
   input  bdes_pkg::word_type from_below,
   input  bdes_pkg::word_type from_above,
   output bdes_pkg::word_type word,
   output bdes_pkg::word_type word_next,
   output bdes_pkg::word_type bottom_part
);
   import bdes_pkg::*;

   word_type word_ff;
   word_type word_in;
   cnt_type  my_pos;

   assign my_pos = CNT_W'(cell_index);

   // A top push moves every word one cell away from the top, a top pop moves
   // them back; a bottom push writes only the first free cell.
   always_comb begin
      word_in = word_ff;
      if (ctrl.push_top) begin
         word_in = from_below;
      end else if (ctrl.pop_top) begin
         word_in = from_above;
      end else if (ctrl.push_bot && (my_pos == ctrl.cnt)) begin
         word_in = value;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   // The cell that will hold the oldest word offers it to the OR tree.
   assign bottom_part = ((ctrl.cnt_next != '0) && (my_pos == ctrl.cnt_next - CNT_W'(1)))
                        ? word_in : '0;
   assign word        = word_ff;
   assign word_next   = word_in;

endmodule

// ===== hw/rtl/bdes_or_group.sv =====
// Sixteen-way OR merge of words of which at most one is nonzero.
// Depends on bdes_pkg.
module bdes_or_group (
   input  bdes_pkg::word_type group_words [bdes_pkg::GRP],
   output bdes_pkg::word_type merged
);
   import bdes_pkg::*;

   always_comb begin
      merged = '0;
      for (int k = 0; k < GRP; k++) begin
         merged = merged | group_words[k];
      end
   end

endmodule

// ===== hw/rtl/bounded_double_ended_stack.sv =====
// Bounded double-ended stack: one word accepted per cycle, busy is never raised.
// Each result passes the s1 and s2 registers and the result register before the
// strobe; the three-level OR tree that gathers the bottom word sets that depth.
// Throughput is one word per cycle and the receiver cannot stall results.
// Synchronous active-high reset empties the stack and clears the strobe pipeline;
// the cell contents are not reset and are never read before being written.
module bounded_double_ended_stack (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  bdes_pkg::word_type req_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_length,
   output bdes_pkg::word_type rsp_top_word,
   output bdes_pkg::word_type rsp_bottom_word
);
   import bdes_pkg::*;

   // Every operation finishes in the cycle it is accepted, so the block is
   // always ready for the next word.
   assign busy = 1'b0;

   logic     accept;
   logic     full;
   logic     empty;
   logic     is_push;
   logic [1:0] status_in;
   cnt_type  cnt_ff;
   cnt_type  cnt_in;
   ctrl_type ctrl;

   assign accept  = start && !busy;
   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign is_push = (req_action == ACT_PUSH_TOP) || (req_action == ACT_PUSH_BOTTOM);

   // Decode the action into chain commands and the next word count.
   always_comb begin
      ctrl.push_top = 1'b0;
      ctrl.pop_top  = 1'b0;
      ctrl.push_bot = 1'b0;
      cnt_in        = cnt_ff;
      status_in     = ST_DONE;
      if (is_push && full) begin
         status_in = ST_FULL;
      end else if (!is_push && empty) begin
         status_in = ST_EMPTY;
      end else if (accept) begin
         case (req_action)
            ACT_PUSH_TOP: begin
               ctrl.push_top = 1'b1;
               cnt_in        = cnt_ff + CNT_W'(1);
            end
            ACT_PUSH_BOTTOM: begin
               ctrl.push_bot = 1'b1;
               cnt_in        = cnt_ff + CNT_W'(1);
            end
            ACT_POP_TOP: begin
               ctrl.pop_top = 1'b1;
               cnt_in       = cnt_ff - CNT_W'(1);
            end
            ACT_POP_BOTTOM: begin
               // The oldest word simply drops out of the counted range.
               cnt_in = cnt_ff - CNT_W'(1);
            end
            default: begin
               cnt_in = cnt_ff;
            end
         endcase
      end
      ctrl.cnt      = cnt_ff;
      ctrl.cnt_next = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // The chain of cells. Cell 0 takes pushes at the top, and each cell reads
   // its neighbors' current words for the shift in either direction.
   word_type cell_word  [DEPTH];
   word_type cell_next  [DEPTH];
   word_type cell_part  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type below_w;
      word_type above_w;
      if (i == 0) begin : g_first
         assign below_w = req_value;
      end else begin : g_inner
         assign below_w = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign above_w = '0;
      end else begin : g_upper
         assign above_w = cell_word[i+1];
      end
      bdes_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(i)),
         .ctrl        (ctrl),
         .value       (req_value),
         .from_below  (below_w),
         .from_above  (above_w),
         .word        (cell_word[i]),
         .word_next   (cell_next[i]),
         .bottom_part (cell_part[i])
      );
   end

   // First tree level works on the next-state words, so the pipeline captures
   // the stack as it stands right after the accepted word.
   word_type lvl0_pad [LVL1_N*GRP];
   word_type lvl1_in  [LVL1_N];
   word_type lvl1_ff  [LVL1_N];

   for (genvar k = 0; k < LVL1_N*GRP; k++) begin : g_pad0
      if (k < DEPTH) begin : g_used
         assign lvl0_pad[k] = cell_part[k];
      end else begin : g_zero
         assign lvl0_pad[k] = '0;
      end
   end

   for (genvar g = 0; g < LVL1_N; g++) begin : g_lvl1
      word_type grp_w [GRP];
      for (genvar j = 0; j < GRP; j++) begin : g_take
         assign grp_w[j] = lvl0_pad[g*GRP + j];
      end
      bdes_or_group u_or (.group_words(grp_w), .merged(lvl1_in[g]));
   end

   word_type lvl1_pad [LVL2_N*GRP];
   word_type lvl2_in  [LVL2_N];
   word_type lvl2_ff  [LVL2_N];

   for (genvar k = 0; k < LVL2_N*GRP; k++) begin : g_pad1
      if (k < LVL1_N) begin : g_used
         assign lvl1_pad[k] = lvl1_ff[k];
      end else begin : g_zero
         assign lvl1_pad[k] = '0;
      end
   end

   for (genvar g = 0; g < LVL2_N; g++) begin : g_lvl2
      word_type grp_w [GRP];
      for (genvar j = 0; j < GRP; j++) begin : g_take
         assign grp_w[j] = lvl1_pad[g*GRP + j];
      end
      bdes_or_group u_or (.group_words(grp_w), .merged(lvl2_in[g]));
   end

   word_type lvl2_pad [GRP];
   word_type bottom_in;

   for (genvar k = 0; k < GRP; k++) begin : g_pad2
      if (k < LVL2_N) begin : g_used
         assign lvl2_pad[k] = lvl2_ff[k];
      end else begin : g_zero
         assign lvl2_pad[k] = '0;
      end
   end

   bdes_or_group u_or_final (.group_words(lvl2_pad), .merged(bottom_in));

   // Side-band fields ride along with the tree levels. The top word is always
   // in cell 0, so it is known in the accepting cycle.
   logic       s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic [1:0] s1_status_ff, s2_status_ff, rsp_status_ff;
   cnt_type    s1_cnt_ff, s2_cnt_ff;
   word_type   s1_top_ff, s2_top_ff, rsp_top_ff, rsp_bottom_ff;
   logic [7:0] rsp_length_ff;
   word_type   top_in;

   assign top_in = (cnt_in != '0) ? cell_next[0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_status_ff  <= status_in;
      s1_cnt_ff     <= cnt_in;
      s1_top_ff     <= top_in;
      lvl1_ff       <= lvl1_in;
      s2_status_ff  <= s1_status_ff;
      s2_cnt_ff     <= s1_cnt_ff;
      s2_top_ff     <= s1_top_ff;
      lvl2_ff       <= lvl2_in;
      rsp_status_ff <= s2_status_ff;
      rsp_length_ff <= 8'(s2_cnt_ff);
      rsp_top_ff    <= s2_top_ff;
      rsp_bottom_ff <= bottom_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_length      = rsp_length_ff;
   assign rsp_top_word    = rsp_top_ff;
   assign rsp_bottom_word = rsp_bottom_ff;

`ifndef SYNTHESIS
   // The word count never runs past the depth of the chain.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("word count exceeds depth");

   // Every accepted word yields its result strobe through the s1, s2 and result valid registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("result strobe missing after accepted word");

   // A rejected push leaves the stack full.
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_length == 8'(DEPTH)))
      else $error("full status with wrong length");

   // An ignored pop reports an empty stack with both end words zero.
   a_empty_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_EMPTY)) |->
      ((rsp_length == 8'd0) && (rsp_top_word == '0) && (rsp_bottom_word == '0)))
      else $error("empty status with nonzero fields");
`endif

endmodule
